// ===== hw/rtl/gdfs_pkg.sv =====
// Shared types and codes for the depth-first component walker.
package gdfs_pkg;

  localparam int unsigned NodeW    = 10;
  localparam int unsigned MaxNode  = 1023;
  localparam int unsigned MaxEdges = 4095;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_NEXT    = 2'd1,
    OP_RESTART = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_ADD_RD,
    S_ADD_A,
    S_ADD_B,
    S_NX_TOP,
    S_NX_TOPW,
    S_NX_ENT,
    S_NX_ENTW,
    S_NX_SEEN,
    S_NX_PUSH,
    S_SC_RD,
    S_SC_CHK,
    S_SC_HEAD,
    S_SC_PUSH,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/graph_dfs_component_walker_core.sv =====
// Depth-first component walker: adjacency lists, visit marks and stack held in memories.
// An add edge request appends one entry to each endpoint's list (a rejected one goes straight
// to the result); next item examines entries from the stack top, pops exhausted levels, then
// scans for an unmarked node to start a new component. Restart sweeps the 1024-entry mark
// memory, clear also the list memory. One request in work at a time; the next is taken
// while the result waits. Reset (rst_n, synchronous) runs the clearing sweep, stalling input.
module graph_dfs_component_walker_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [gdfs_pkg::NodeW-1:0] cfg_node_count,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic [gdfs_pkg::NodeW-1:0] in_node_a,
  input  logic [gdfs_pkg::NodeW-1:0] in_node_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [gdfs_pkg::NodeW-1:0] out_visited_node,
  output logic [gdfs_pkg::NodeW-1:0] out_component,
  output logic                     out_done_res,
  output logic [1:0]               out_status
);
  import gdfs_pkg::*;

  localparam int unsigned Slots  = MaxNode + 1;
  localparam int unsigned NW     = $clog2(Slots);
  localparam int unsigned Ents   = 2 * MaxEdges;
  localparam int unsigned EW     = $clog2(Ents + 1);   // link = index+1, 0 null
  localparam int unsigned SW     = $clog2(Slots + 1);
  localparam int unsigned EIW    = (Ents > 1) ? $clog2(Ents) : 1;

  // memories
  logic [2*EW-1:0] lst_mem [Slots];   // {head, tail}
  logic [NW+EW-1:0] ent_mem [Ents];   // {target, link}
  logic            seen_mem [Slots];
  logic [NW+EW-1:0] stk_mem [Slots];  // {node, cursor}

  state_t state_r, state_nxt;
  logic [NodeW-1:0] ncount_r;
  logic [1:0]       op_r;
  logic [NodeW-1:0] a_r, b_r;
  logic [EW-1:0]    fill_r, fill_nxt;
  logic [SW-1:0]    lvl_r, lvl_nxt;
  logic [NW:0]      scan_r, scan_nxt;
  logic [NodeW-1:0] comp_r, comp_nxt;
  logic [NW:0]      clr_r, clr_nxt;
  logic             clr_lst_r, clr_lst_nxt;
  logic [EW-1:0]    cur_r, cur_nxt;
  logic [NW-1:0]    tgt_r, tgt_nxt;
  logic [NodeW-1:0] vis_r, vis_nxt;
  logic             done_r, done_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             ov_r;

  // memory ports
  logic [2*EW-1:0]  lst_q;
  logic [NW+EW-1:0] ent_q, stk_q;
  logic             seen_q;
  logic             lst_we, ent_we, seen_we, stk_we, seen_wd;
  logic [NW-1:0]    lst_ra, lst_wa, seen_ra, seen_wa;
  logic [EIW-1:0]   ent_ra, ent_wa;
  logic [SW-1:0]    stk_ra, stk_wa;
  logic [2*EW-1:0]  lst_wd;
  logic [NW+EW-1:0] ent_wd, stk_wd;
  logic             ent2_we;
  logic [EIW-1:0]   ent2_wa;
  logic [EW-1:0]    ent2_link;

  always_ff @(posedge clk) begin
    if (lst_we) lst_mem[lst_wa] <= lst_wd;
    lst_q <= lst_mem[lst_ra];
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    else if (ent2_we) ent_mem[ent2_wa][EW-1:0] <= ent2_link;
    ent_q <= ent_mem[ent_ra];
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    seen_q <= seen_mem[seen_ra];
    if (stk_we) stk_mem[stk_wa[NW-1:0]] <= stk_wd;
    stk_q <= stk_mem[stk_ra[NW-1:0]];
  end

  // effective node count
  logic [NW:0] neff;
  always_comb begin
    if ({1'b0, ncount_r} < (NodeW+1)'(MaxNode)) neff = (NW+1)'(ncount_r);
    else neff = (NW+1)'(MaxNode);
  end

  logic acc;
  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;

  // result moves to the output register once the previous one is gone
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!ov_r || !out_stall);

  // current list of the endpoint being appended
  logic [NW-1:0]  from_n, to_n;
  logic [EW-1:0]  tail_v;
  assign tail_v = lst_q[EW-1:0];

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r; lvl_nxt = lvl_r; scan_nxt = scan_r; comp_nxt = comp_r;
    clr_nxt = clr_r; clr_lst_nxt = clr_lst_r; cur_nxt = cur_r; tgt_nxt = tgt_r;
    vis_nxt = vis_r; done_nxt = done_r; st_nxt = st_r;
    lst_we = 1'b0; ent_we = 1'b0; seen_we = 1'b0; stk_we = 1'b0; ent2_we = 1'b0;
    seen_wd = 1'b0; lst_wd = '0; ent_wd = '0; stk_wd = '0; ent2_link = '0;
    lst_ra = '0; lst_wa = '0; seen_ra = '0; seen_wa = '0;
    ent_ra = '0; ent_wa = '0; ent2_wa = '0; stk_ra = lvl_r - 1'b1; stk_wa = '0;
    from_n = (state_r == S_ADD_B) ? b_r[NW-1:0] : a_r[NW-1:0];
    to_n   = (state_r == S_ADD_B) ? a_r[NW-1:0] : b_r[NW-1:0];
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          vis_nxt = '0; done_nxt = 1'b0; st_nxt = ST_OK;
          case (op_t'(in_op))
            OP_ADD: begin
              if (in_node_a == '0 || in_node_b == '0 ||
                  (NW+1)'(in_node_a) > neff || (NW+1)'(in_node_b) > neff) begin
                st_nxt = ST_RANGE; state_nxt = S_OUT;
              end else if (32'(fill_r) + 32'd2 > 32'(Ents)) begin
                st_nxt = ST_FULL; state_nxt = S_OUT;
              end else begin
                lst_ra = in_node_a[NW-1:0]; state_nxt = S_ADD_A;
              end
            end
            OP_NEXT: state_nxt = S_NX_TOP;
            OP_RESTART: begin
              clr_nxt = '0; clr_lst_nxt = 1'b0; state_nxt = S_CLR;
            end
            default: begin
              clr_nxt = '0; clr_lst_nxt = 1'b1; fill_nxt = '0; state_nxt = S_CLR;
            end
          endcase
        end
      end
      S_CLR: begin
        seen_we = 1'b1; seen_wa = clr_r[NW-1:0]; seen_wd = 1'b0;
        lst_we = clr_lst_r; lst_wa = clr_r[NW-1:0]; lst_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (NW+1)'(Slots - 1)) begin
          lvl_nxt = '0; scan_nxt = (NW+1)'(1); comp_nxt = '0;
          state_nxt = (op_r == OP_RESTART || op_r == OP_CLEAR) ? S_OUT : S_IDLE;
        end
      end
      S_ADD_A, S_ADD_B: begin
        // append fill_r to list of from_n
        ent_we = 1'b1; ent_wa = fill_r[EIW-1:0]; ent_wd = {to_n, {EW{1'b0}}};
        lst_we = 1'b1; lst_wa = from_n;
        lst_wd = {(tail_v == '0) ? fill_r + 1'b1 : lst_q[2*EW-1:EW], fill_r + 1'b1};
        fill_nxt = fill_r + 1'b1;
        cur_nxt = tail_v; // remember old tail for link patch
        state_nxt = (state_r == S_ADD_A) ? S_ADD_RD : S_OUT;
        if (state_r == S_ADD_B) state_nxt = S_NX_PUSH; // patch step reused below
        tgt_nxt = from_n;
      end
      S_ADD_RD: begin
        // patch old tail link of node a, then read list of node b
        ent2_we = (cur_r != '0); ent2_wa = EIW'(cur_r - 1'b1); ent2_link = fill_r;
        lst_ra = b_r[NW-1:0];
        state_nxt = S_ADD_B;
      end
      S_NX_PUSH: begin
        if (op_r == OP_ADD) begin
          ent2_we = (cur_r != '0); ent2_wa = EIW'(cur_r - 1'b1); ent2_link = fill_r;
          state_nxt = S_OUT;
        end else begin
          // push tgt_r: mark it, stack gets {node, head}
          seen_we = 1'b1; seen_wa = tgt_r; seen_wd = 1'b1;
          stk_we = (lvl_r < SW'(Slots)); stk_wa = lvl_r;
          stk_wd = {tgt_r, lst_q[2*EW-1:EW]};
          if (lvl_r < SW'(Slots)) lvl_nxt = lvl_r + 1'b1;
          vis_nxt = NodeW'(tgt_r);
          state_nxt = S_OUT;
        end
      end
      S_NX_TOP: begin
        if (lvl_r == '0) state_nxt = S_SC_RD;
        else begin
          stk_ra = lvl_r - 1'b1; state_nxt = S_NX_TOPW;
        end
      end
      S_NX_TOPW: begin
        cur_nxt = stk_q[EW-1:0]; state_nxt = S_NX_ENT;
      end
      S_NX_ENT: begin
        if (cur_r == '0 || 32'(cur_r) > 32'(Ents)) begin
          lvl_nxt = lvl_r - 1'b1; state_nxt = S_NX_TOP;
        end else begin
          ent_ra = EIW'(cur_r - 1'b1); state_nxt = S_NX_ENTW;
        end
      end
      S_NX_ENTW: begin
        tgt_nxt = ent_q[NW+EW-1:EW]; cur_nxt = ent_q[EW-1:0];
        seen_ra = ent_q[NW+EW-1:EW]; lst_ra = ent_q[NW+EW-1:EW];
        state_nxt = S_NX_SEEN;
      end
      S_NX_SEEN: begin
        if (!seen_q) begin
          // save advanced cursor on top, then push
          stk_we = 1'b1; stk_wa = lvl_r - 1'b1; stk_wd = {stk_q[NW+EW-1:EW], cur_r};
          lst_ra = tgt_r;
          state_nxt = S_SC_PUSH;
        end else state_nxt = S_NX_ENT;
      end
      S_SC_PUSH: begin
        // list read is valid again; do the push
        seen_we = 1'b1; seen_wa = tgt_r; seen_wd = 1'b1;
        stk_we = (lvl_r < SW'(Slots)); stk_wa = lvl_r;
        stk_wd = {tgt_r, lst_q[2*EW-1:EW]};
        if (lvl_r < SW'(Slots)) lvl_nxt = lvl_r + 1'b1;
        vis_nxt = NodeW'(tgt_r);
        state_nxt = S_OUT;
      end
      S_SC_RD: begin
        if (scan_r >= (NW+1)'(1) && scan_r <= neff) begin
          seen_ra = scan_r[NW-1:0]; lst_ra = scan_r[NW-1:0]; state_nxt = S_SC_CHK;
        end else begin
          done_nxt = 1'b1; state_nxt = S_OUT;
        end
      end
      S_SC_CHK: begin
        if (!seen_q) begin
          tgt_nxt = scan_r[NW-1:0]; comp_nxt = comp_r + 1'b1;
          lst_ra = scan_r[NW-1:0]; state_nxt = S_SC_HEAD;
        end else begin
          scan_nxt = scan_r + 1'b1; state_nxt = S_SC_RD;
        end
      end
      S_SC_HEAD: begin
        // keep the start node's list on the read port for the push
        lst_ra = tgt_r; state_nxt = S_SC_PUSH;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; clr_lst_r <= 1'b1; op_r <= OP_NEXT;
      ncount_r <= '0; fill_r <= '0; lvl_r <= '0; scan_r <= (NW+1)'(1);
      comp_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; clr_lst_r <= clr_lst_nxt;
      fill_r <= fill_nxt; lvl_r <= lvl_nxt; scan_r <= scan_nxt; comp_r <= comp_nxt;
      if (cfg_we) ncount_r <= cfg_node_count;
      if (acc) op_r <= in_op;
      if (out_load) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_r <= in_node_a; b_r <= in_node_b;
    end
    cur_r <= cur_nxt; tgt_r <= tgt_nxt;
    vis_r <= vis_nxt; done_r <= done_nxt; st_r <= st_nxt;
    if (out_load) begin
      out_visited_node <= vis_r;
      out_component    <= comp_r;
      out_done_res     <= done_r;
      out_status       <= st_r;
    end
  end

  assign out_valid = ov_r;

endmodule

// ===== dv/graph_dfs_component_walker_core_tb.sv =====
// Testbench for the depth-first component walker: directed and random request stream checked against a walk model.
`timescale 1ns / 100ps

module graph_dfs_component_walker_core_tb;
  import gdfs_pkg::*;

  localparam int unsigned NodeSlots  = 1024;
  localparam int unsigned EdgeMax    = 4095;
  localparam int unsigned EntrySlots = 2 * EdgeMax;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned CfgSettle  = 8;

  typedef struct {
    bit                is_cfg;
    op_t               op;
    logic [NodeW-1:0]  a;
    logic [NodeW-1:0]  b;
  } request_t;

  typedef struct {
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] comp;
    logic             done;
    status_t          st;
  } walk_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [NodeW-1:0] cfg_node_count = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_op = OP_NEXT;
  logic [NodeW-1:0] in_node_a = '0;
  logic [NodeW-1:0] in_node_b = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [NodeW-1:0] out_visited_node;
  logic [NodeW-1:0] out_component;
  logic             out_done_res;
  logic [1:0]       out_status;

  graph_dfs_component_walker_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_node_count   (cfg_node_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_visited_node (out_visited_node),
    .out_component    (out_component),
    .out_done_res     (out_done_res),
    .out_status       (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walk model state
  logic [NodeW-1:0] nodes_cfg;
  logic [12:0]      adj_head [NodeSlots];
  logic [12:0]      adj_tail [NodeSlots];
  logic [NodeW-1:0] adj_target [EntrySlots];
  logic [12:0]      adj_link [EntrySlots];
  int unsigned      adj_fill;
  bit               visited [NodeSlots];
  logic [NodeW-1:0] dfs_node [NodeSlots];
  logic [12:0]      dfs_cursor [NodeSlots];
  int unsigned      dfs_depth;
  int unsigned      scan_pos;
  logic [NodeW-1:0] comp_count;

  request_t     pending_requests[$];
  walk_result_t expected_results[$];
  int unsigned  errors = 0;
  int unsigned  n_requests = 0, n_results = 0, n_cfg = 0;
  int unsigned  n_done = 0, n_full = 0, n_range = 0;

  function automatic void restart_walk();
    for (int i = 0; i < NodeSlots; i++) visited[i] = 1'b0;
    dfs_depth  = 0;
    scan_pos   = 1;
    comp_count = '0;
  endfunction

  function automatic void clear_lists();
    for (int i = 0; i < NodeSlots; i++) begin
      adj_head[i] = '0;
      adj_tail[i] = '0;
    end
    adj_fill = 0;
  endfunction

  function automatic void append_neighbor(int unsigned from, logic [NodeW-1:0] to);
    int unsigned idx;
    idx = adj_fill;
    adj_target[idx] = to;
    adj_link[idx]   = '0;
    if (adj_tail[from] == 0) adj_head[from] = 13'(idx + 1);
    else adj_link[adj_tail[from] - 1] = 13'(idx + 1);
    adj_tail[from] = 13'(idx + 1);
    adj_fill = idx + 1;
  endfunction

  function automatic void mark_and_push(logic [NodeW-1:0] v);
    visited[v] = 1'b1;
    dfs_node[dfs_depth]   = v;
    dfs_cursor[dfs_depth] = adj_head[v];
    dfs_depth++;
  endfunction

  // Next node in preorder, zero once every node has been reached
  function automatic logic [NodeW-1:0] next_preorder();
    int unsigned      top;
    logic [12:0]      cur;
    logic [NodeW-1:0] t;
    while (dfs_depth > 0) begin
      top = dfs_depth - 1;
      cur = dfs_cursor[top];
      while (cur != 0) begin
        t   = adj_target[cur - 1];
        cur = adj_link[cur - 1];
        if (!visited[t]) begin
          dfs_cursor[top] = cur;
          mark_and_push(t);
          return t;
        end
      end
      dfs_depth = top;
    end
    while (scan_pos >= 1 && scan_pos <= nodes_cfg) begin
      if (!visited[scan_pos]) begin
        comp_count = comp_count + 1'b1;
        mark_and_push(NodeW'(scan_pos));
        return NodeW'(scan_pos);
      end
      scan_pos++;
    end
    return '0;
  endfunction

  function automatic void predict_request(request_t r);
    walk_result_t res;
    res.node = '0;
    res.done = 1'b0;
    res.st   = ST_OK;
    case (r.op)
      OP_ADD: begin
        if (r.a == 0 || r.b == 0 || r.a > nodes_cfg || r.b > nodes_cfg) res.st = ST_RANGE;
        else if (adj_fill + 2 > EntrySlots) res.st = ST_FULL;
        else begin
          append_neighbor(r.a, r.b);
          append_neighbor(r.b, r.a);
        end
      end
      OP_NEXT: begin
        res.node = next_preorder();
        res.done = (res.node == 0);
      end
      OP_RESTART: restart_walk();
      default: begin
        clear_lists();
        restart_walk();
      end
    endcase
    res.comp = comp_count;
    expected_results.insert(expected_results.size(), res);
  endfunction

  function automatic void queue_request(op_t op, int unsigned a, int unsigned b);
    request_t r;
    r.is_cfg = 1'b0;
    r.op = op;
    r.a  = NodeW'(a);
    r.b  = NodeW'(b);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void queue_node_count(int unsigned n);
    request_t r;
    r.is_cfg = 1'b1;
    r.op = OP_NEXT;
    r.a  = NodeW'(n);
    r.b  = '0;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // Driver: one request at a time from the pending queue, random gaps
  request_t    cur_req;
  int unsigned send_gap = 0, settle = 0;
  bit          send_quiet = 1'b0;
  always @(posedge clk) begin
    bit holding, valid_n, we_n;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
    end else begin
      holding = in_valid;
      we_n    = 1'b0;
      if (in_valid && !in_stall) begin
        predict_request(cur_req);
        n_requests++;
        holding = 1'b0;
        if (n_requests % 300 == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 13);
      end
      valid_n = holding;
      if (!holding && pending_requests.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests[0].is_cfg) begin
          // register written only once the block has gone idle
          if (expected_results.size() != 0) begin
            settle = 0;
          end else if (settle < CfgSettle) begin
            settle++;
          end else begin
            settle = 0;
            we_n = 1'b1;
            nodes_cfg = pending_requests[0].a;
            cfg_node_count <= pending_requests[0].a;
            void'(pending_requests.pop_front());
            n_cfg++;
          end
        end else begin
          cur_req = pending_requests.pop_front();
          in_op     <= cur_req.op;
          in_node_a <= cur_req.a;
          in_node_b <= cur_req.b;
          valid_n = 1'b1;
        end
      end
      in_valid <= valid_n;
      cfg_we   <= we_n;
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: random stalls plus one long hold-off to back up the block
  int unsigned recv_wait = 0, hold_off = 0;
  bit          recv_quiet = 1'b0, hold_done = 1'b0;
  always @(posedge clk) begin
    walk_result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: node %0d comp %0d", $time, out_visited_node,
                   out_component);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("visited_node", exp_r.node, out_visited_node);
          check_field("component", exp_r.comp, out_component);
          check_field("done_res", exp_r.done, out_done_res);
          check_field("status", exp_r.st, out_status);
          if (exp_r.done) n_done++;
          if (exp_r.st == ST_FULL) n_full++;
          if (exp_r.st == ST_RANGE) n_range++;
        end
        if (n_results % 250 == 0) recv_quiet = !recv_quiet;
        recv_wait = recv_quiet ? 0 : $urandom_range(0, 13);
        if (!hold_done && n_results == 400) begin
          hold_off  = 500;
          hold_done = 1'b1;
        end
      end
      if (hold_off > 0) hold_off--;
      else if (recv_wait > 0) recv_wait--;
      out_stall <= (hold_off > 0) || (recv_wait > 0);
    end
  end

  // Watchdog on cycles without progress
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Build a graph from random add requests, endpoints mostly in range, then walk it
  function automatic void queue_walk_phase(int unsigned n, int unsigned m);
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(0, 9) == 0 || n == 0)
        queue_request(OP_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        queue_request(OP_ADD, $urandom_range(1, n), $urandom_range(1, n));
    end
    for (int i = 0; i < n + 2; i++) begin
      if ($urandom_range(0, 49) == 0) queue_request(OP_RESTART, $urandom, $urandom);
      else if ($urandom_range(0, 79) == 0)
        queue_request(OP_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else queue_request(OP_NEXT, $urandom, $urandom);
    end
  endfunction

  initial begin
    int unsigned n;
    nodes_cfg = '0;
    clear_lists();
    restart_walk();

    // directed: empty graph, bad endpoints, self loop, count changed mid walk
    queue_request(OP_NEXT, 0, 0);
    queue_request(OP_ADD, 1, 1);
    queue_node_count(5);
    queue_request(OP_ADD, 1, 2);
    queue_request(OP_ADD, 2, 3);
    queue_request(OP_ADD, 4, 4);
    queue_request(OP_ADD, 0, 1);
    queue_request(OP_ADD, 1, 6);
    queue_request(OP_ADD, 1023, 5);
    for (int i = 0; i < 3; i++) queue_request(OP_NEXT, 1023, 1023);
    queue_request(OP_RESTART, 0, 0);
    for (int i = 0; i < 4; i++) queue_request(OP_NEXT, 0, 0);
    queue_node_count(3);
    for (int i = 0; i < 3; i++) queue_request(OP_NEXT, 0, 0);
    queue_request(OP_CLEAR, 1023, 1023);
    queue_request(OP_NEXT, 0, 0);
    queue_node_count(1023);
    queue_request(OP_ADD, 1023, 1);
    queue_request(OP_NEXT, 0, 0);
    queue_request(OP_NEXT, 0, 0);
    queue_request(OP_NEXT, 0, 0);

    // random phases over several node counts
    for (int p = 0; p < 13; p++) begin
      case ($urandom_range(0, 5))
        0:       n = $urandom_range(0, 2);
        default: n = $urandom_range(3, 60);
      endcase
      queue_node_count(n);
      queue_request(OP_CLEAR, $urandom, $urandom);
      queue_walk_phase(n, $urandom_range(0, 2 * n + 4));
    end

    // largest count: walk steps over a sparse graph
    queue_node_count(1023);
    queue_request(OP_CLEAR, 0, 0);
    queue_walk_phase(1023, 60);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (1200) @(posedge clk);

    $display("covered %0d requests, %0d results, %0d count writes", n_requests, n_results,
             n_cfg);
    $display("walks finished %0d, store-full %0d, out-of-range %0d", n_done, n_full, n_range);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
